// ===== rtl/button_debounce_press_classifier_unit_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the button debounce and press classifier
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// -----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define BDPC_ASSERT_NOW(lbl, clk_s, rstn_s, trig, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (trig) |-> (cond)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define BDPC_ASSERT_NEXT(lbl, clk_s, rstn_s, trig, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== rtl/bdpc_pkg.sv =====
// -----------------------------------------------------------------------------
// Button debounce and press classifier package
// Event codes, register indexes, stream widths, output field positions and reset values.
// -----------------------------------------------------------------------------
package bdpc_pkg;

	// Classified press events.
	typedef enum logic [1:0] {
		EV_SHORT   = 2'd0,
		EV_LONG    = 2'd1,
		EV_FACTORY = 2'd2
	} ev_code_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_DEBOUNCE  = 2'd0,
		CFG_SHORT_MAX = 2'd1,
		CFG_LONG_MIN  = 2'd2,
		CFG_RESET_MIN = 2'd3
	} cfg_idx_t;

	localparam int CFG_INDEX_W = 2;

	// Stream data widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;

	// Output field positions inside the result tdata.
	localparam int OUT_PRESSED_BIT = 0;
	localparam int OUT_EVVALID_BIT = 1;
	localparam int OUT_CODE_LSB    = 2;

	// Register reset values.
	localparam int unsigned DEBOUNCE_RST  = 20;
	localparam int unsigned SHORT_MAX_RST = 2000;
	localparam int unsigned LONG_MIN_RST  = 5000;
	localparam int unsigned RESET_MIN_RST = 10000;

endpackage

// ===== rtl/button_debounce_press_classifier_unit.sv =====
// A result transaction is registered and appears in the cycle after its tick is accepted.
// Throughput: one tick per cycle unless the sink stalls; the update is one pass
// of counters and compares between the input handshake and result register.
// Reset: arst_n clears all but the payload asynchronously; registers go to
// debounce 20, short 2000, long 5000, factory reset 10000 ticks; button released.
// -----------------------------------------------------------------------------
// Button debounce and press classifier
// Debounces an active-low button sampled once per tick and classifies each
// completed press by its duration as short, long, factory reset or no event.
// -----------------------------------------------------------------------------
`include "button_debounce_press_classifier_unit_macros.svh"

module button_debounce_press_classifier_unit #(
	parameter int QUIET_WIDTH    = 10,
	parameter int DURATION_WIDTH = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [bdpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [DURATION_WIDTH-1:0]           cfg_wdata,
	// Tick input: [0] raw_level, [7:1] zero.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [bdpc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Result: [0] stable_pressed, [1] event_valid, [3:2] event_code, [7:4] zero.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bdpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	// Configuration registers.
	logic [QUIET_WIDTH-1:0]    debounce_q;
	logic [DURATION_WIDTH-1:0] short_max_q;
	logic [DURATION_WIDTH-1:0] long_min_q;
	logic [DURATION_WIDTH-1:0] reset_min_q;

	// Debounce and press state.
	logic                      previous_raw_q;
	logic [QUIET_WIDTH-1:0]    quiet_count_q;
	logic                      armed_q;
	logic                      stable_level_q;
	logic                      press_active_q;
	logic [DURATION_WIDTH-1:0] press_ticks_q;

	// Result register.
	logic                      out_valid_q;
	logic [bdpc_pkg::OUT_TDATA_W-1:0] out_data_q;

	// Next-state values for one tick.
	logic                      accept;
	logic                      raw;
	logic [QUIET_WIDTH-1:0]    limit;
	logic [QUIET_WIDTH-1:0]    quiet_inc;
	logic [DURATION_WIDTH-1:0] press_inc;
	logic                      expire;
	logic                      level_change;
	logic                      previous_raw_d;
	logic [QUIET_WIDTH-1:0]    quiet_count_d;
	logic                      armed_d;
	logic                      stable_level_d;
	logic                      press_active_d;
	logic [DURATION_WIDTH-1:0] press_ticks_d;
	logic                      ev_valid;
	bdpc_pkg::ev_code_t        ev_code;

	// The input side stalls only when a result waits and the sink is not taking it.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign raw           = s_axis_tdata[0];

	// Configuration writes; indexes outside the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= QUIET_WIDTH'(bdpc_pkg::DEBOUNCE_RST);
			short_max_q <= DURATION_WIDTH'(bdpc_pkg::SHORT_MAX_RST);
			long_min_q  <= DURATION_WIDTH'(bdpc_pkg::LONG_MIN_RST);
			reset_min_q <= DURATION_WIDTH'(bdpc_pkg::RESET_MIN_RST);
		end else if (cfg_we) begin
			case (bdpc_pkg::cfg_idx_t'(cfg_index))
				bdpc_pkg::CFG_DEBOUNCE:  debounce_q  <= cfg_wdata[QUIET_WIDTH-1:0];
				bdpc_pkg::CFG_SHORT_MAX: short_max_q <= cfg_wdata;
				bdpc_pkg::CFG_LONG_MIN:  long_min_q  <= cfg_wdata;
				bdpc_pkg::CFG_RESET_MIN: reset_min_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Saturating counter increments and the effective debounce limit.
	always_comb begin
		limit     = (debounce_q == '0) ? QUIET_WIDTH'(1) : debounce_q;
		quiet_inc = (quiet_count_q != '1) ? quiet_count_q + QUIET_WIDTH'(1) : quiet_count_q;
		press_inc = (press_active_q && press_ticks_q != '1) ?
			press_ticks_q + DURATION_WIDTH'(1) : press_ticks_q;
	end

	// Debounce count: a raw edge restarts it, quiet ticks count it up to the limit.
	always_comb begin
		previous_raw_d = previous_raw_q;
		quiet_count_d  = quiet_count_q;
		armed_d        = armed_q;
		expire         = 1'b0;
		if (raw != previous_raw_q) begin
			previous_raw_d = raw;
			quiet_count_d  = '0;
			armed_d        = 1'b1;
		end else if (armed_q) begin
			quiet_count_d = quiet_inc;
			if (quiet_inc >= limit) begin
				expire  = 1'b1;
				armed_d = 1'b0;
			end
		end
	end

	// Stable level update and press classification on release.
	always_comb begin
		level_change   = expire && (raw != stable_level_q);
		stable_level_d = stable_level_q;
		press_active_d = press_active_q;
		press_ticks_d  = press_inc;
		ev_valid       = 1'b0;
		ev_code        = bdpc_pkg::EV_SHORT;
		if (level_change) begin
			stable_level_d = raw;
			if (!raw) begin
				press_active_d = 1'b1;
				press_ticks_d  = '0;
			end else if (press_active_q) begin
				press_active_d = 1'b0;
				// Fixed test order: short first, then factory reset, then long.
				if (press_inc < short_max_q) begin
					ev_valid = 1'b1;
					ev_code  = bdpc_pkg::EV_SHORT;
				end else if (press_inc >= reset_min_q) begin
					ev_valid = 1'b1;
					ev_code  = bdpc_pkg::EV_FACTORY;
				end else if (press_inc >= long_min_q) begin
					ev_valid = 1'b1;
					ev_code  = bdpc_pkg::EV_LONG;
				end
			end
		end
	end

	// State registers advance on each accepted tick transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_raw_q <= 1'b1;
			quiet_count_q  <= '0;
			armed_q        <= 1'b0;
			stable_level_q <= 1'b1;
			press_active_q <= 1'b0;
			press_ticks_q  <= '0;
		end else if (accept) begin
			previous_raw_q <= previous_raw_d;
			quiet_count_q  <= quiet_count_d;
			armed_q        <= armed_d;
			stable_level_q <= stable_level_d;
			press_active_q <= press_active_d;
			press_ticks_q  <= press_ticks_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= s_axis_tvalid;
		end
	end

	// Result payload, loaded with each accepted tick.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {4'b0000, ev_code, ev_valid, !stable_level_d};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Assertions.
	`BDPC_ASSERT_NOW(a_press_while_low, clk, arst_n, press_active_q, !stable_level_q, "press active while stable level is released")
	`BDPC_ASSERT_NOW(a_event_released, clk, arst_n, m_axis_tvalid && m_axis_tdata[bdpc_pkg::OUT_EVVALID_BIT], !m_axis_tdata[bdpc_pkg::OUT_PRESSED_BIT], "event reported while button still pressed")
	`BDPC_ASSERT_NOW(a_code_idle_zero, clk, arst_n, m_axis_tvalid && !m_axis_tdata[bdpc_pkg::OUT_EVVALID_BIT], m_axis_tdata[bdpc_pkg::OUT_CODE_LSB+1:bdpc_pkg::OUT_CODE_LSB] == 2'b00, "event code nonzero without event")
	`BDPC_ASSERT_NEXT(a_accept_result, clk, arst_n, accept, m_axis_tvalid, "accepted tick produced no result")

endmodule

// ===== tb/tb_top.sv =====
// -----------------------------------------------------------------------------
// Testbench for the button debounce and press classifier
// Streams raw button ticks into the block, predicts the debounced state and
// the press event of every tick with a cycle-free model kept in this file,
// and checks each result transaction in order. Covers reset values, directed
// press lengths, threshold extremes, a long debounce and random traffic
// with sender gaps and receiver stalls.
// -----------------------------------------------------------------------------
module tb_top;

	localparam int QUIET_W        = 10;
	localparam int DUR_W          = 24;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int BLOCK_LATENCY  = 1;

	// Expected contents of one result transaction.
	typedef struct packed {
		logic               pressed;
		logic               ev_valid;
		bdpc_pkg::ev_code_t code;
	} button_report_t;

	logic                               clk;
	logic                               arst_n        = 1'b0;
	logic                               cfg_we        = 1'b0;
	logic [bdpc_pkg::CFG_INDEX_W-1:0]   cfg_index     = '0;
	logic [DUR_W-1:0]                   cfg_wdata     = '0;
	logic                               s_axis_tvalid = 1'b0;
	logic                               s_axis_tready;
	logic [bdpc_pkg::IN_TDATA_W-1:0]    s_axis_tdata  = '0;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready = 1'b0;
	logic [bdpc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata;

	// Register copies and button state of the predictor.
	logic [QUIET_W-1:0] deb_ticks;
	logic [DUR_W-1:0]   short_max;
	logic [DUR_W-1:0]   long_min;
	logic [DUR_W-1:0]   factory_min;
	logic               prev_raw;
	logic [QUIET_W-1:0] quiet_cnt;
	logic               armed;
	logic               stable_lvl;
	logic               pressing;
	logic [DUR_W-1:0]   press_cnt;

	button_report_t button_reports_q[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int ticks_sent     = 0;
	int results_seen   = 0;
	int mismatches     = 0;
	int quiet_cycles   = 0;

	button_debounce_press_classifier_unit #(
		.QUIET_WIDTH   (QUIET_W),
		.DURATION_WIDTH(DUR_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Sorts a finished press by its duration; the short test comes first.
	function automatic logic classify_press(input logic [DUR_W-1:0] dur,
			output bdpc_pkg::ev_code_t code);
		code = bdpc_pkg::EV_SHORT;
		if (dur < short_max) begin
			return 1'b1;
		end else if (dur >= factory_min) begin
			code = bdpc_pkg::EV_FACTORY;
			return 1'b1;
		end else if (dur >= long_min) begin
			code = bdpc_pkg::EV_LONG;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advances the button model by one tick and returns the expected result.
	function automatic button_report_t debounce_and_classify(input logic raw);
		logic [QUIET_W-1:0] limit;
		logic               expire;
		bdpc_pkg::ev_code_t code;
		button_report_t     rep;
		limit        = (deb_ticks == '0) ? QUIET_W'(1) : deb_ticks;
		expire       = 1'b0;
		code         = bdpc_pkg::EV_SHORT;
		rep.ev_valid = 1'b0;
		if (pressing && press_cnt != '1) begin
			press_cnt = press_cnt + 1'b1;
		end
		if (raw != prev_raw) begin
			prev_raw  = raw;
			quiet_cnt = '0;
			armed     = 1'b1;
		end else if (armed) begin
			if (quiet_cnt != '1) begin
				quiet_cnt = quiet_cnt + 1'b1;
			end
			if (quiet_cnt >= limit) begin
				expire = 1'b1;
				armed  = 1'b0;
			end
		end
		if (expire && raw != stable_lvl) begin
			stable_lvl = raw;
			if (!raw) begin
				pressing  = 1'b1;
				press_cnt = '0;
			end else if (pressing) begin
				pressing     = 1'b0;
				rep.ev_valid = classify_press(press_cnt, code);
				if (!rep.ev_valid) begin
					code = bdpc_pkg::EV_SHORT;
				end
			end
		end
		rep.pressed = !stable_lvl;
		rep.code    = code;
		return rep;
	endfunction

	task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		if (mismatches <= 100) begin
			$display("mismatch in %s at result %0d: expected %0h, got %0h",
				what, results_seen, want, got);
		end
	endtask

	// Each result transaction is compared with the oldest pending prediction.
	always @(posedge clk) begin : check_result
		button_report_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (button_reports_q.size() == 0) begin
				flag_mismatch("unexpected result", 8'h00, m_axis_tdata);
			end else begin
				want = button_reports_q.pop_front();
				if (m_axis_tdata[bdpc_pkg::OUT_PRESSED_BIT] !== want.pressed) begin
					flag_mismatch("stable_pressed", 8'(want.pressed),
						8'(m_axis_tdata[bdpc_pkg::OUT_PRESSED_BIT]));
				end
				if (m_axis_tdata[bdpc_pkg::OUT_EVVALID_BIT] !== want.ev_valid) begin
					flag_mismatch("event_valid", 8'(want.ev_valid),
						8'(m_axis_tdata[bdpc_pkg::OUT_EVVALID_BIT]));
				end
				if (m_axis_tdata[bdpc_pkg::OUT_CODE_LSB +: 2] !== want.code) begin
					flag_mismatch("event_code", 8'(want.code),
						8'(m_axis_tdata[bdpc_pkg::OUT_CODE_LSB +: 2]));
				end
				if (m_axis_tdata[bdpc_pkg::OUT_TDATA_W-1:bdpc_pkg::OUT_CODE_LSB+2] !== '0) begin
					flag_mismatch("padding", 8'h00, m_axis_tdata);
				end
			end
			results_seen++;
		end
	end

	// Receiver readiness, stalling at the rate of the current phase.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[button_debounce_press_classifier_unit] ERROR");
				$finish;
			end
		end
	end

	// Offers one tick and records its prediction once the transaction is taken.
	task automatic send_tick(input logic raw);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(bdpc_pkg::IN_TDATA_W-1){1'b0}}, raw};
		do @(posedge clk); while (!s_axis_tready);
		button_reports_q.push_back(debounce_and_classify(raw));
		ticks_sent++;
	endtask

	task automatic hold(input logic raw, input int n);
		repeat (n) send_tick(raw);
	endtask

	task automatic chatter(input int n);
		repeat (n) send_tick($urandom_range(0, 1));
	endtask

	task automatic press_release(input int low_ticks, input int high_ticks, input int bounce);
		chatter(bounce);
		hold(1'b0, low_ticks);
		chatter(bounce);
		hold(1'b1, high_ticks);
	endtask

	// Stops sending and waits until every predicted result has arrived.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (button_reports_q.size() != 0) @(posedge clk);
		repeat (BLOCK_LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_reg(input bdpc_pkg::cfg_idx_t idx, input logic [DUR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			bdpc_pkg::CFG_DEBOUNCE:  deb_ticks   = value[QUIET_W-1:0];
			bdpc_pkg::CFG_SHORT_MAX: short_max   = value;
			bdpc_pkg::CFG_LONG_MIN:  long_min    = value;
			bdpc_pkg::CFG_RESET_MIN: factory_min = value;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [DUR_W-1:0] deb, input logic [DUR_W-1:0] s,
			input logic [DUR_W-1:0] l, input logic [DUR_W-1:0] r);
		wait_idle();
		set_reg(bdpc_pkg::CFG_DEBOUNCE, deb);
		set_reg(bdpc_pkg::CFG_SHORT_MAX, s);
		set_reg(bdpc_pkg::CFG_LONG_MIN, l);
		set_reg(bdpc_pkg::CFG_RESET_MIN, r);
	endtask

	// A short press under the register values left by reset.
	task automatic test_default_registers();
		press_release(60, 40, 3);
	endtask

	// Zero debounce acting as one tick, a glitch, and one press of each class.
	task automatic test_directed_presses();
		configure(0, 3, 4, 5);
		hold(1'b0, 1);
		hold(1'b1, 1);
		hold(1'b0, 2);
		hold(1'b1, 2);
		hold(1'b0, 3);
		hold(1'b1, 2);
		hold(1'b0, 4);
		hold(1'b1, 2);
		hold(1'b0, 5);
		hold(1'b1, 2);
	endtask

	// Thresholds at both ends of their range, and out of order.
	task automatic test_threshold_extremes();
		logic [DUR_W-1:0] set_deb[6];
		logic [DUR_W-1:0] set_short[6];
		logic [DUR_W-1:0] set_long[6];
		logic [DUR_W-1:0] set_factory[6];
		set_deb     = '{24'hFFFC01, 1, 2, 1, 1, 3};
		set_short   = '{'1, 0, 0, 0, 10, 8};
		set_long    = '{'1, 0, 0, '1, 3, 5};
		set_factory = '{'1, 0, '1, '1, 2, 6};
		for (int i = 0; i < 6; i++) begin
			configure(set_deb[i], set_short[i], set_long[i], set_factory[i]);
			repeat (3) begin
				press_release(set_deb[i][QUIET_W-1:0] + 1 + $urandom_range(0, 12),
					set_deb[i][QUIET_W-1:0] + 1, 0);
			end
		end
	endtask

	// A long debounce: a low run just too short, then a full press.
	task automatic test_slow_debounce();
		configure(50, 0, 40, 120);
		hold(1'b0, 45);
		hold(1'b1, 55);
		hold(1'b0, 60);
		hold(1'b1, 55);
	endtask

	task automatic random_config();
		logic [DUR_W-1:0] d;
		logic [DUR_W-1:0] s;
		logic [DUR_W-1:0] l;
		logic [DUR_W-1:0] r;
		d = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
		if ($urandom_range(0, 4) == 0) begin
			s = $urandom_range(0, 40);
			l = $urandom_range(0, 40);
			r = $urandom_range(0, 40);
		end else begin
			s = $urandom_range(0, 20);
			l = s + $urandom_range(0, 20);
			r = l + $urandom_range(0, 20);
		end
		configure(d, s, l, r);
	endtask

	// Mostly clean presses of random length, with chatter and broken presses.
	task automatic random_episode();
		int kind;
		int lim;
		lim  = (deb_ticks == '0) ? 1 : deb_ticks;
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			chatter($urandom_range(1, 8));
		end else if (kind == 1) begin
			hold(1'b0, $urandom_range(1, lim));
			hold(1'b1, lim + 1);
		end else if (kind == 2) begin
			hold(1'b0, lim + 1 + $urandom_range(0, 20));
			hold(1'b1, $urandom_range(1, lim));
			hold(1'b0, $urandom_range(1, 20));
			hold(1'b1, lim + 1);
		end else begin
			press_release(lim + 1 + $urandom_range(0, 45), lim + 1 + $urandom_range(0, 4),
				$urandom_range(0, 3));
		end
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
		int start;
		int block_start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		start          = ticks_sent;
		block_start    = ticks_sent;
		random_config();
		while (ticks_sent - start < n) begin
			if (ticks_sent - block_start >= 75) begin
				random_config();
				block_start = ticks_sent;
			end else if ($urandom_range(0, 29) == 0) begin
				// Hold off the sender until the block has drained.
				wait_idle();
			end
			random_episode();
		end
	endtask

	initial begin
		deb_ticks   = QUIET_W'(bdpc_pkg::DEBOUNCE_RST);
		short_max   = DUR_W'(bdpc_pkg::SHORT_MAX_RST);
		long_min    = DUR_W'(bdpc_pkg::LONG_MIN_RST);
		factory_min = DUR_W'(bdpc_pkg::RESET_MIN_RST);
		prev_raw    = 1'b1;
		quiet_cnt   = '0;
		armed       = 1'b0;
		stable_lvl  = 1'b1;
		pressing    = 1'b0;
		press_cnt   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_directed_presses();
		test_threshold_extremes();
		test_slow_debounce();
		test_random_traffic(0, 0, 100);
		test_random_traffic(53, 0, 100);
		test_random_traffic(0, 53, 100);
		test_random_traffic(23, 23, 100);

		wait_idle();
		repeat (BLOCK_LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && button_reports_q.size() == 0) begin
			$display("[button_debounce_press_classifier_unit] OK");
		end else begin
			$display("[button_debounce_press_classifier_unit] ERROR");
		end
		$finish;
	end

endmodule

// ===== button_debounce_press_classifier_unit.f =====
+incdir+rtl
rtl/bdpc_pkg.sv
rtl/button_debounce_press_classifier_unit.sv
tb/tb_top.sv
